FILE: hdl/rcem_pkg.sv
// Shared types and constants of the Roberts cross edge magnitude block.
// Used by the channel interfaces, the front end, the square root cells and the top level.
`default_nettype none

package rcem_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // Sum of two squared 9-bit differences, and the square root datapath.
    localparam int SUM_W     = 17;
    localparam int RAD_W     = SUM_W + 1;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 1;
    localparam int REM_SH_W  = REM_W + 2;
    localparam int SQ_STEPS  = RAD_W / 2;

    // Bit positions of the pending result mask, in emission order.
    localparam int RES_MAG = 0;
    localparam int RES_COL = 1;
    localparam int RES_ROW = 2;
    localparam int RES_N   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0]   above;
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               has_mag;
        logic               has_colcopy;
        logic               has_rowcopy;
        logic               frame_end;
    } rcem_side_t;

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        rcem_side_t        side;
    } rcem_sq_t;

endpackage

`default_nettype wire

FILE: hdl/rcem_ifs.sv
// Valid/ready channel interfaces for input pixels and result items.
// Payload widths come from rcem_pkg.
`default_nettype none

interface rcem_pix_if;
    logic                       valid;
    logic                       ready;
    logic [rcem_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface rcem_res_if;
    logic                         valid;
    logic                         ready;
    logic [rcem_pkg::PIX_W-1:0]   pixel_out;
    logic [rcem_pkg::COORD_W-1:0] out_row;
    logic [rcem_pkg::COORD_W-1:0] out_col;
    logic                         is_border;
    logic                         frame_last;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output is_border, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input is_border, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/rcem_sqrt_cell.sv
// One cell of the square root chain: retires one root bit per cell.
// Depends on rcem_pkg for the cell payload struct.
`default_nettype none

module rcem_sqrt_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rcem_pkg::rcem_sq_t up,
    output logic                    up_ready,
    output rcem_pkg::rcem_sq_t      dn,
    input  wire logic               dn_ready
);
    import rcem_pkg::*;

    logic                valid_reg;
    rcem_sq_t            data_reg;
    rcem_sq_t            data_next;
    logic [REM_SH_W-1:0] rem_sh;
    logic [REM_SH_W-1:0] trial;
    logic [REM_SH_W-1:0] diff;

    assign up_ready = !valid_reg || dn_ready;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb
    begin
        rem_sh    = {up.rem, up.rad[RAD_W-1 -: 2]};
        trial     = {1'b0, up.root, 2'b01};
        diff      = rem_sh - trial;
        data_next = up;
        data_next.rad = {up.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            data_next.rem  = diff[REM_W-1:0];
            data_next.root = {up.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh[REM_W-1:0];
            data_next.root = {up.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up.valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        dn       = data_reg;
        dn.valid = valid_reg;
    end

endmodule

`default_nettype wire

FILE: hdl/rcem_front.sv
// Front end: configuration registers, raster counters, line store and the squared sum.
// Depends on rcem_pkg and the pixel channel interface in rcem_ifs.
`default_nettype none

module rcem_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rcem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rcem_pkg::CFG_W-1:0]     cfg_data,
    rcem_pix_if.sink                            pixels,
    output rcem_pkg::rcem_sq_t                  dn,
    input  wire logic                           dn_ready
);
    import rcem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CW-1:0]    col_last;
    logic [RW-1:0]    row_last;
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic             last_col;
    logic             last_row;
    logic             accept;

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] above_reg;

    logic             s0_valid_reg;
    rcem_side_t       s0_side_reg;
    rcem_side_t       s0_side_next;

    logic             s1_valid_reg;
    logic             s1_ready;
    logic             xfer;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    rcem_side_t       s1_side_reg;
    rcem_side_t       s1_side_next;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] ul_reg;

    logic signed [PIX_W:0]     d1;
    logic signed [PIX_W:0]     d2;
    logic signed [2*PIX_W+1:0] p1;
    logic signed [2*PIX_W+1:0] p2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Last column and row index, with the registers clamped to [2, MAX].
    always_comb
    begin
        if (width_reg < CFG_W'(2))
            col_last = CW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            col_last = CW'(MAX_WIDTH - 1);
        else
            col_last = CW'(32'(width_reg) - 32'd1);

        if (height_reg < CFG_W'(2))
            row_last = RW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            row_last = RW'(MAX_HEIGHT - 1);
        else
            row_last = RW'(32'(height_reg) - 32'd1);
    end

    assign last_col     = (col_reg == col_last);
    assign last_row     = (row_reg == row_last);
    assign s1_ready     = !s1_valid_reg || dn_ready;
    assign xfer         = s0_valid_reg && s1_ready;
    assign pixels.ready = !s0_valid_reg || s1_ready;
    assign accept       = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Read before write: the read returns the pixel of the row above.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= pixels.pixel_in;
            above_reg         <= line_mem[col_reg];
        end
    end

    always_comb
    begin
        s0_side_next.above       = '0;
        s0_side_next.pix         = pixels.pixel_in;
        s0_side_next.row         = COORD_W'(row_reg);
        s0_side_next.col         = COORD_W'(col_reg);
        s0_side_next.has_mag     = (row_reg != '0) && (col_reg != '0);
        s0_side_next.has_colcopy = (row_reg != '0) && last_col;
        s0_side_next.has_rowcopy = last_row;
        s0_side_next.frame_end   = last_row && last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (pixels.ready)
        begin
            s0_valid_reg <= pixels.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_side_reg <= s0_side_next;
        end
    end

    // The left and upper-left neighbors are the previous item's pixel and above value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            ul_reg   <= '0;
        end
        else if (cfg_we)
        begin
            left_reg <= '0;
            ul_reg   <= '0;
        end
        else if (xfer)
        begin
            left_reg <= s0_side_reg.pix;
            ul_reg   <= above_reg;
        end
    end

    always_comb
    begin
        d1       = $signed({1'b0, ul_reg}) - $signed({1'b0, s0_side_reg.pix});
        d2       = $signed({1'b0, left_reg}) - $signed({1'b0, above_reg});
        p1       = d1 * d1;
        p2       = d2 * d2;
        sum_next = {1'b0, p1[2*PIX_W-1:0]} + {1'b0, p2[2*PIX_W-1:0]};
        s1_side_next       = s0_side_reg;
        s1_side_next.above = above_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            sum_reg     <= sum_next;
            s1_side_reg <= s1_side_next;
        end
    end

    always_comb
    begin
        dn.valid = s1_valid_reg;
        dn.rad   = {1'b0, sum_reg};
        dn.rem   = '0;
        dn.root  = '0;
        dn.side  = s1_side_reg;
    end

endmodule

`default_nettype wire

FILE: hdl/roberts_cross_edge_magnitude.sv
// Roberts cross edge magnitude over a raster stream of gray pixels.
// Stages: line store read, squared sum, nine square root cells, result register.
// Throughput: one pixel per cycle while results are taken; an item with k results holds
// the result register until all k are taken (two at the end of a middle row, up to
// three in the last row).
// Reset: 640 x 480 image, counters and neighbor pixels cleared; the line store is not cleared.
`default_nettype none

module roberts_cross_edge_magnitude #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rcem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rcem_pkg::CFG_W-1:0]     cfg_data,
    rcem_pix_if.sink                            pixels,
    rcem_res_if.source                          results
);
    import rcem_pkg::*;

    rcem_sq_t         chain       [SQ_STEPS+1];
    logic             chain_ready [SQ_STEPS+1];

    logic [RES_N-1:0] pend_reg;
    logic [RES_N-1:0] pend_low;
    logic [PIX_W-1:0] mag_reg;
    rcem_side_t       side_reg;
    logic             emit_ready;
    logic             load;
    logic             last_one;

    rcem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .dn        (chain[0]),
        .dn_ready  (chain_ready[0])
    );

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_cell
        rcem_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up       (chain[i]),
            .up_ready (chain_ready[i]),
            .dn       (chain[i+1]),
            .dn_ready (chain_ready[i+1])
        );
    end

    assign last_one   = $onehot(pend_reg);
    assign pend_low   = pend_reg & (~pend_reg + 1'b1);
    assign emit_ready = (pend_reg == '0) || (last_one && results.ready);
    assign load       = chain[SQ_STEPS].valid && emit_ready;
    assign chain_ready[SQ_STEPS] = emit_ready;

    // Each item leaves up to three results; the mask holds the ones not yet taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (emit_ready)
        begin
            pend_reg <= chain[SQ_STEPS].valid ?
                        {chain[SQ_STEPS].side.has_rowcopy,
                         chain[SQ_STEPS].side.has_colcopy,
                         chain[SQ_STEPS].side.has_mag} : '0;
        end
        else if (results.ready)
        begin
            pend_reg <= pend_reg & ~pend_low;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg  <= chain[SQ_STEPS].root[ROOT_W-1] ? '1 : chain[SQ_STEPS].root[PIX_W-1:0];
            side_reg <= chain[SQ_STEPS].side;
        end
    end

    always_comb
    begin
        results.valid      = (pend_reg != '0);
        results.frame_last = side_reg.frame_end && last_one;
        if (pend_reg[RES_MAG])
        begin
            results.pixel_out = mag_reg;
            results.out_row   = side_reg.row - 1'b1;
            results.out_col   = side_reg.col - 1'b1;
            results.is_border = 1'b0;
        end
        else if (pend_reg[RES_COL])
        begin
            results.pixel_out = side_reg.above;
            results.out_row   = side_reg.row - 1'b1;
            results.out_col   = side_reg.col;
            results.is_border = 1'b1;
        end
        else
        begin
            results.pixel_out = side_reg.pix;
            results.out_row   = side_reg.row;
            results.out_col   = side_reg.col;
            results.is_border = 1'b1;
        end
    end

    // The final result of an image is always a copied border pixel.
    a_frame_last_border: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.frame_last |-> results.is_border)
        else $error("frame_last on a magnitude result");

    // Taking a result that is not the item's last leaves the next one on offer.
    a_item_continues: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && !last_one |=> results.valid)
        else $error("result item dropped between results of one pixel");

    // A magnitude is pending only for a pixel past the first row and the first column.
    a_mag_only_inner: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg[RES_MAG] |-> side_reg.has_mag)
        else $error("magnitude pending for a pixel without one");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for roberts_cross_edge_magnitude: a scoreboard model of the edge stream.
// Needs rcem_pkg, the channel interfaces in rcem_ifs.sv and the block itself.

module tb_top;
    import rcem_pkg::*;

    localparam int unsigned MAX_DIM       = 2048;
    localparam int unsigned RANDOM_ITEMS  = 120;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned HOLD_AT       = 80;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam longint      WATCHDOG_NS   = 5_000_000;

    // Index past the register list; a write there only restarts the frame.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               border;
        logic               last;
    } out_pixel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rcem_pix_if pix_ch ();
    rcem_res_if res_ch ();

    roberts_cross_edge_magnitude DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_ch),
        .results   (res_ch)
    );

    logic [PIX_W-1:0] pixels_to_send [$];
    out_pixel_t       expected_pixels [$];
    int unsigned      pixels_accepted = 0;
    int unsigned      mismatches      = 0;
    logic             quiet_run       = 1'b0;
    logic             hold_results    = 1'b0;

    // Image state as the block should hold it.
    logic [CFG_W-1:0] cfg_width  = WIDTH_RESET;
    logic [CFG_W-1:0] cfg_height = HEIGHT_RESET;
    logic [PIX_W-1:0] prev_row [MAX_DIM];
    logic [PIX_W-1:0] left_px   = '0;
    logic [PIX_W-1:0] upleft_px = '0;
    int unsigned      cur_row   = 0;
    int unsigned      cur_col   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    function automatic void add_pixel(input logic [PIX_W-1:0] px);
        pixels_to_send = {pixels_to_send, px};
    endfunction

    function automatic void add_expected(input out_pixel_t item);
        expected_pixels = {expected_pixels, item};
    endfunction

    // Works out the results that one accepted pixel causes and queues them in order.
    function automatic void predict_edges(input logic [PIX_W-1:0] px);
        int unsigned      w, h, r, c, sum, root;
        int               d1, d2;
        logic [PIX_W-1:0] above;
        logic             last_col, last_row;
        out_pixel_t       item;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        r = (cur_row >= h) ? h - 1 : cur_row;
        c = (cur_col >= w) ? w - 1 : cur_col;
        last_col = (c == w - 1);
        last_row = (r == h - 1);
        above = prev_row[c];

        if (r >= 1 && c >= 1)
        begin
            d1 = int'(upleft_px) - int'(px);
            d2 = int'(left_px) - int'(above);
            sum = d1 * d1 + d2 * d2;
            root = 0;
            for (int b = 8; b >= 0; b--)
            begin
                if ((root + (1 << b)) * (root + (1 << b)) <= sum)
                    root += (1 << b);
            end
            item.value  = (root > 255) ? 8'd255 : root[7:0];
            item.row    = COORD_W'(r - 1);
            item.col    = COORD_W'(c - 1);
            item.border = 1'b0;
            item.last   = 1'b0;
            add_expected(item);
        end
        if (r >= 1 && last_col)
        begin
            item.value  = above;
            item.row    = COORD_W'(r - 1);
            item.col    = COORD_W'(c);
            item.border = 1'b1;
            item.last   = 1'b0;
            add_expected(item);
        end
        // The last-row copy is always the final result of its step, so in the last column
        // it carries the end-of-image flag.
        if (last_row)
        begin
            item.value  = px;
            item.row    = COORD_W'(r);
            item.col    = COORD_W'(c);
            item.border = 1'b1;
            item.last   = last_col;
            add_expected(item);
        end

        upleft_px = above;
        left_px = px;
        prev_row[c] = px;
        if (last_col)
        begin
            cur_col = 0;
            cur_row = last_row ? 0 : r + 1;
        end
        else
        begin
            cur_col = c + 1;
            cur_row = r;
        end
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return CFG_W'($urandom_range(1, 0));
            1:       return CFG_W'($urandom_range(4095, 2049));
            default: return CFG_W'($urandom_range(9, 2));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = val;
        else if (idx == REG_IMAGE_HEIGHT)
            cfg_height = val;
        // Any write starts a new image.
        cur_row = 0;
        cur_col = 0;
        left_px = '0;
        upleft_px = '0;
    endtask

    task automatic queue_random_pixels(input int unsigned count);
        @(negedge clk);
        repeat (count)
        begin
            case ($urandom_range(7))
                0:       add_pixel(8'd0);
                1:       add_pixel(8'd255);
                default: add_pixel(PIX_W'($urandom_range(255)));
            endcase
        end
    endtask

    // Pixels of the first row of an image give no results, so the pipeline may still be busy
    // once the queue is empty; give it time to settle.
    task automatic drain_results();
        while (pixels_to_send.size() != 0 || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pixel sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ch.valid    <= 1'b0;
            pix_ch.pixel_in <= '0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                predict_edges(pix_ch.pixel_in);
                void'(pixels_to_send.pop_front());
                pixels_accepted++;
            end
            if (pix_ch.valid && !pix_ch.ready)
            begin
                // The offered item stays on the bus until it is taken.
            end
            else if (pixels_to_send.size() != 0 && (quiet_run || $urandom_range(99) >= 8))
            begin
                pix_ch.valid    <= 1'b1;
                pix_ch.pixel_in <= pixels_to_send[0];
            end
            else
            begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        out_pixel_t seen, want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                seen.value  = res_ch.pixel_out;
                seen.row    = res_ch.out_row;
                seen.col    = res_ch.out_col;
                seen.border = res_ch.is_border;
                seen.last   = res_ch.frame_last;
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result %0d (%0d,%0d) b%0b l%0b", $time,
                                 seen.value, seen.row, seen.col, seen.border, seen.last);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (seen.value !== want.value || seen.row !== want.row ||
                        seen.col !== want.col || seen.border !== want.border ||
                        seen.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected %0d (%0d,%0d) b%0b l%0b", $time,
                                     want.value, want.row, want.col, want.border, want.last);
                            $display("%0t: got      %0d (%0d,%0d) b%0b l%0b", $time,
                                     seen.value, seen.row, seen.col, seen.border, seen.last);
                        end
                    end
                end
            end
            res_ch.ready <= !hold_results && (quiet_run || $urandom_range(99) >= 8);
        end
    end

    // Long receiver stall in the middle of the 10 x 8 image, so the block backs up.
    initial
    begin
        wait (pixels_accepted >= HOLD_AT);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [PIX_W-1:0] directed_frames [16] = '{
            8'd255, 8'd0,   8'd255, 8'd0,     // both differences at full scale: saturates
            8'd10,  8'd10,  8'd14,  8'd7,     // differences 3 and 4 give exactly 5
            8'd0,   8'd0,   8'd0,   8'd0,
            8'd0,   8'd255, 8'd255, 8'd0      // large pixels but zero magnitude
        };
        int unsigned w_eff, h_eff, count, random_pixels;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pix_ch.valid    = 1'b0;
        pix_ch.pixel_in = '0;
        res_ch.ready    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Default size after reset: a few pixels of the first row, which give no results.
        queue_random_pixels(6);
        drain_results();

        // Values below the minimum clamp to a 2 x 2 image.
        write_reg(REG_IMAGE_WIDTH, 12'd0);
        write_reg(REG_IMAGE_HEIGHT, 12'd1);
        @(negedge clk);
        foreach (directed_frames[i])
            add_pixel(directed_frames[i]);
        add_pixel(8'd200);
        add_pixel(8'd1);
        add_pixel(8'd128);
        drain_results();

        // A write to an unused index in mid image only restarts the image.
        write_reg(REG_SPARE, CFG_W'($urandom_range(4095)));
        @(negedge clk);
        add_pixel(8'd90);
        add_pixel(8'd3);
        add_pixel(8'd250);
        add_pixel(8'd66);
        drain_results();

        // Widest image, clamped from the top of the register range; first row only.
        write_reg(REG_IMAGE_WIDTH, 12'd4095);
        write_reg(REG_IMAGE_HEIGHT, 12'd0);
        queue_random_pixels(16);
        drain_results();

        // A whole 10 x 8 image; the receiver stalls while it streams.
        write_reg(REG_IMAGE_WIDTH, 12'd10);
        write_reg(REG_IMAGE_HEIGHT, 12'd8);
        queue_random_pixels(80);
        drain_results();

        // Tallest image, streamed with neither side idling.
        write_reg(REG_IMAGE_WIDTH, 12'd2);
        write_reg(REG_IMAGE_HEIGHT, 12'd2048);
        quiet_run <= 1'b1;
        queue_random_pixels(48);
        drain_results();
        quiet_run <= 1'b0;

        // Random sizes: mostly whole small images, some partial ones.
        random_pixels = 0;
        while (random_pixels < RANDOM_ITEMS)
        begin
            if ($urandom_range(3) != 0)
                write_reg(REG_IMAGE_WIDTH, pick_dim());
            if ($urandom_range(3) != 0)
                write_reg(REG_IMAGE_HEIGHT, pick_dim());
            if ($urandom_range(9) == 0)
                write_reg(REG_SPARE, CFG_W'($urandom_range(4095)));
            w_eff = clamp_dim(cfg_width);
            h_eff = clamp_dim(cfg_height);
            if (w_eff * h_eff <= 40 && $urandom_range(3) != 0)
                count = w_eff * h_eff * $urandom_range(2, 1);
            else
                count = $urandom_range(40, 1);
            queue_random_pixels(count);
            random_pixels += count;
            drain_results();
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
